### rtl/vdre_pkg.sv
// shared types, codes and helper functions of the visibility diff run encoder
package vdre_pkg;

    localparam int STATUS_W = 3;
    localparam int PAGE_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLY_CHANGED = 1'd1;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [STATUS_W-1:0] ST_OUT_OF_FILE = 3'd4;
    localparam logic [COUNT_W-1:0]  COUNT_MAX      = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0] code_old;
        logic [STATUS_W-1:0] code_new;
        logic                final_page;
    } in_word_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   start_pg;
        logic [PAGE_W-1:0]   run_end;
        logic [STATUS_W-1:0] run_old;
        logic [STATUS_W-1:0] run_new;
        logic                run_valid;
        logic                last;
        logic [COUNT_W-1:0]  tot_changed;
        logic [COUNT_W-1:0]  tot_vis_gain;
        logic [COUNT_W-1:0]  tot_vis_loss;
        logic [COUNT_W-1:0]  tot_frz_gain;
        logic [COUNT_W-1:0]  tot_frz_loss;
        logic [COUNT_W-1:0]  run_count;
    } out_word_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic has_vis(input logic [STATUS_W-1:0] code);
        return (code < ST_OUT_OF_FILE) && code[0];
    endfunction

    function automatic logic has_frz(input logic [STATUS_W-1:0] code);
        return (code < ST_OUT_OF_FILE) && code[1];
    endfunction

endpackage

### rtl/visibility_diff_run_encoder_core.sv
// visibility diff run encoder: run merging, stream totals and result queue
//
// Each input word carries the old and new visibility status of one heap page; pages are
// numbered from first_page, one per word. Neighboring pages with the same status pair are
// merged into a run, and a run is reported when the pair changes and on the word marked
// final_page, whose result also carries the stream totals (last = 1); runs whose old and
// new status are equal are not reported while only_changed is set. One word is taken per
// clock cycle as long as the four-entry result queue has two free slots; results leave it
// at one per cycle while m_ready is high, so a word that closes a run and ends the stream
// yields two results. Run state, the saturating counters and the result queue update in
// the accept cycle, and the queue entries are the output registers. Configuration writes
// on cfg_* take effect at once; first_page is sampled when a stream starts.
module visibility_diff_run_encoder_core
    import vdre_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_word
);

    logic [PAGE_W-1:0]   first_page_reg;
    logic                only_changed_reg;

    logic                in_run_reg, in_run_next;
    logic [PAGE_W-1:0]   cur_start_reg, cur_start_next;
    logic [PAGE_W-1:0]   cur_page_reg, cur_page_next;
    logic [STATUS_W-1:0] cur_old_reg, cur_old_next;
    logic [STATUS_W-1:0] cur_new_reg, cur_new_next;
    logic [COUNT_W-1:0]  cnt_changed_reg, cnt_changed_next;
    logic [COUNT_W-1:0]  cnt_gain_vis_reg, cnt_gain_vis_next;
    logic [COUNT_W-1:0]  cnt_loss_vis_reg, cnt_loss_vis_next;
    logic [COUNT_W-1:0]  cnt_gain_frz_reg, cnt_gain_frz_next;
    logic [COUNT_W-1:0]  cnt_loss_frz_reg, cnt_loss_frz_next;
    logic [COUNT_W-1:0]  cnt_runs_reg, cnt_runs_next;

    out_word_t           fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]    count_reg, count_next;

    logic                accept, pop;
    logic [PAGE_W-1:0]   page;
    logic                pair_diff, new_run, emit_close, show_final;
    logic [PAGE_W-1:0]   run_start_eff;
    logic [STATUS_W-1:0] run_old_eff, run_new_eff;
    logic [COUNT_W-1:0]  changed_upd, gain_vis_upd, loss_vis_upd;
    logic [COUNT_W-1:0]  gain_frz_upd, loss_frz_upd, runs_upd;
    logic                ov, nv, of, nf, st_diff;
    out_word_t           close_word, final_word, push0_word;
    logic                push0, push1;
    logic [1:0]          n_push;

    assign s_ready = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign accept  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_word  = fifo_reg[rd_ptr_reg];

    always_comb begin
        page          = in_run_reg ? cur_page_reg + 1'b1 : first_page_reg;
        pair_diff     = (s_word.code_old != cur_old_reg) || (s_word.code_new != cur_new_reg);
        new_run       = !in_run_reg || pair_diff;
        emit_close    = in_run_reg && pair_diff && !(only_changed_reg && cur_old_reg == cur_new_reg);
        run_start_eff = new_run ? page : cur_start_reg;
        run_old_eff   = new_run ? s_word.code_old : cur_old_reg;
        run_new_eff   = new_run ? s_word.code_new : cur_new_reg;
        show_final    = !(only_changed_reg && run_old_eff == run_new_eff);

        ov      = has_vis(s_word.code_old);
        nv      = has_vis(s_word.code_new);
        of      = has_frz(s_word.code_old);
        nf      = has_frz(s_word.code_new);
        st_diff = (s_word.code_old != s_word.code_new);

        changed_upd  = st_diff ? sat_inc(cnt_changed_reg) : cnt_changed_reg;
        gain_vis_upd = (st_diff && !ov && nv) ? sat_inc(cnt_gain_vis_reg) : cnt_gain_vis_reg;
        loss_vis_upd = (st_diff && ov && !nv) ? sat_inc(cnt_loss_vis_reg) : cnt_loss_vis_reg;
        gain_frz_upd = (st_diff && !of && nf) ? sat_inc(cnt_gain_frz_reg) : cnt_gain_frz_reg;
        loss_frz_upd = (st_diff && of && !nf) ? sat_inc(cnt_loss_frz_reg) : cnt_loss_frz_reg;
        runs_upd     = new_run ? sat_inc(cnt_runs_reg) : cnt_runs_reg;

        close_word           = '0;
        close_word.start_pg  = cur_start_reg;
        close_word.run_end   = cur_page_reg;
        close_word.run_old   = cur_old_reg;
        close_word.run_new   = cur_new_reg;
        close_word.run_valid = 1'b1;

        final_word = '0;
        if (show_final) begin
            final_word.start_pg  = run_start_eff;
            final_word.run_end   = page;
            final_word.run_old   = run_old_eff;
            final_word.run_new   = run_new_eff;
            final_word.run_valid = 1'b1;
        end
        final_word.last         = 1'b1;
        final_word.tot_changed  = changed_upd;
        final_word.tot_vis_gain = gain_vis_upd;
        final_word.tot_vis_loss = loss_vis_upd;
        final_word.tot_frz_gain = gain_frz_upd;
        final_word.tot_frz_loss = loss_frz_upd;
        final_word.run_count    = runs_upd;

        push0      = accept && (emit_close || s_word.final_page);
        push1      = accept && emit_close && s_word.final_page;
        push0_word = emit_close ? close_word : final_word;
        n_push     = {1'b0, push0} + {1'b0, push1};
    end

    always_comb begin
        in_run_next       = in_run_reg;
        cur_start_next    = cur_start_reg;
        cur_page_next     = cur_page_reg;
        cur_old_next      = cur_old_reg;
        cur_new_next      = cur_new_reg;
        cnt_changed_next  = cnt_changed_reg;
        cnt_gain_vis_next = cnt_gain_vis_reg;
        cnt_loss_vis_next = cnt_loss_vis_reg;
        cnt_gain_frz_next = cnt_gain_frz_reg;
        cnt_loss_frz_next = cnt_loss_frz_reg;
        cnt_runs_next     = cnt_runs_reg;
        if (accept) begin
            if (s_word.final_page) begin
                in_run_next       = 1'b0;
                cur_start_next    = '0;
                cur_page_next     = '0;
                cur_old_next      = '0;
                cur_new_next      = '0;
                cnt_changed_next  = '0;
                cnt_gain_vis_next = '0;
                cnt_loss_vis_next = '0;
                cnt_gain_frz_next = '0;
                cnt_loss_frz_next = '0;
                cnt_runs_next     = '0;
            end else begin
                in_run_next       = 1'b1;
                cur_start_next    = run_start_eff;
                cur_page_next     = page;
                cur_old_next      = run_old_eff;
                cur_new_next      = run_new_eff;
                cnt_changed_next  = changed_upd;
                cnt_gain_vis_next = gain_vis_upd;
                cnt_loss_vis_next = loss_vis_upd;
                cnt_gain_frz_next = gain_frz_upd;
                cnt_loss_frz_next = loss_frz_upd;
                cnt_runs_next     = runs_upd;
            end
        end
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_page_reg   <= '0;
            only_changed_reg <= 1'b0;
            in_run_reg       <= 1'b0;
            cur_start_reg    <= '0;
            cur_page_reg     <= '0;
            cur_old_reg      <= '0;
            cur_new_reg      <= '0;
            cnt_changed_reg  <= '0;
            cnt_gain_vis_reg <= '0;
            cnt_loss_vis_reg <= '0;
            cnt_gain_frz_reg <= '0;
            cnt_loss_frz_reg <= '0;
            cnt_runs_reg     <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FIRST_PAGE:   first_page_reg   <= cfg_data[PAGE_W-1:0];
                    CFG_ONLY_CHANGED: only_changed_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            in_run_reg       <= in_run_next;
            cur_start_reg    <= cur_start_next;
            cur_page_reg     <= cur_page_next;
            cur_old_reg      <= cur_old_next;
            cur_new_reg      <= cur_new_next;
            cnt_changed_reg  <= cnt_changed_next;
            cnt_gain_vis_reg <= cnt_gain_vis_next;
            cnt_loss_vis_reg <= cnt_loss_vis_next;
            cnt_gain_frz_reg <= cnt_gain_frz_next;
            cnt_loss_frz_reg <= cnt_loss_frz_next;
            cnt_runs_reg     <= cnt_runs_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            count_reg        <= count_next;
        end
    end

    // result queue storage, no reset
    always_ff @(posedge aclk) begin
        if (push0) begin
            fifo_reg[wr_ptr_reg] <= push0_word;
        end
        if (push1) begin
            fifo_reg[wr_ptr_reg + 1'b1] <= final_word;
        end
    end

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_stream_end: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_word.final_page |=> !in_run_reg && cnt_runs_reg == '0)
        else $error("stream state not cleared after final word");

    a_stream_open: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_word.final_page |=> in_run_reg && cnt_runs_reg != '0)
        else $error("run not open after a non-final word");

    a_totals_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.last |-> m_word.run_count == '0 && m_word.tot_changed == '0)
        else $error("totals on a result that is not last");

    a_close_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.last |-> m_word.run_valid)
        else $error("closed run reported without run_valid");

endmodule
